@@ hdl/wrs_pkg.sv @@
`timescale 1ns / 1ps

package wrs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 3 * DATA_W;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_LOOKUP = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    localparam status_t STATUS_DONE   = 2'd0;
    localparam status_t STATUS_ZERO   = 2'd1;
    localparam status_t STATUS_REJECT = 2'd2;
    localparam status_t STATUS_EMPTY  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] end_val;
        logic [DATA_W-1:0] type_val;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_RESULT
    } state_t;

endpackage

@@ hdl/weighted_roulette_selector.sv @@
`timescale 1ns / 1ps

// Weighted roulette selector. Add, clear and the unused kind go from idle straight to the
// result state; the result reaches the output register once it can take it, and the input
// is ready again once it is loaded. A lookup reduces the random value when it is not below
// the total weight (the bit-serial remainder unit, one quotient bit a cycle, then hands the
// remainder over) and scans the table in order, one read of the entry memory per cycle, up
// to the first entry whose end value exceeds the random value or the last entry. One item
// is worked on at a time; the next item is accepted while the previous result waits on the
// output, and a finished result waits while the output register is still full.
module weighted_roulette_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_type [31:0], weight [63:32], random_value [95:64]
    input  logic [wrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  logic [wrs_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // selected_type [31:0]
    output logic [wrs_pkg::DATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [wrs_pkg::STATUS_W-1:0]    m_axis_tuser
);

    import wrs_pkg::*;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] rnd_reg, rnd_next;
    logic [DATA_W-1:0] res_type_reg, res_type_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_type_reg, out_type_next;
    status_t           out_status_reg, out_status_next;

    logic              accept;
    kind_t             in_kind;
    logic [DATA_W-1:0] in_type;
    logic [DATA_W-1:0] in_weight;
    logic [DATA_W-1:0] in_rnd;
    logic [DATA_W:0]   sum;
    logic              add_ok;
    logic              wr_en;
    entry_t            wr_data;
    entry_t            rd_data;
    logic [IDX_W-1:0]  rd_addr;
    logic              mod_start;
    logic              mod_done;
    logic [DATA_W-1:0] mod_rem;
    logic              scan_hit;
    logic              scan_last;
    logic              load_out;

    assign in_kind   = s_axis_tuser;
    assign in_type   = s_axis_tdata[DATA_W-1:0];
    assign in_weight = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign in_rnd    = s_axis_tdata[3*DATA_W-1:2*DATA_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign sum    = {1'b0, total_reg} + {1'b0, in_weight};
    assign add_ok = (in_weight != '0) && (count_reg < CNT_W'(MAX_ENTRIES)) && !sum[DATA_W];

    assign wr_en            = accept && (in_kind == KIND_ADD) && add_ok;
    assign wr_data.end_val  = sum[DATA_W-1:0];
    assign wr_data.type_val = in_type;

    assign rd_addr   = (state_reg == S_SCAN) ? idx_reg + 1'b1 : '0;
    assign scan_hit  = rnd_reg < rd_data.end_val;
    assign scan_last = ({1'b0, idx_reg} + 1'b1) >= count_reg;

    assign mod_start = accept && (in_kind == KIND_LOOKUP) && (total_reg != '0)
                       && (in_rnd >= total_reg);

    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || m_axis_tready);

    wrs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wrs_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_rnd),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_kind == KIND_LOOKUP) && (total_reg != '0))
                    begin
                        state_next = mod_start ? S_MOD : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        total_next      = total_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rnd_next        = rnd_reg;
        res_type_next   = res_type_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        out_status_next = out_status_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_type_next   = '0;
                    res_status_next = STATUS_DONE;
                    idx_next        = '0;
                    rnd_next        = in_rnd;
                    case (in_kind)
                        KIND_ADD:
                        begin
                            if (in_weight == '0)
                            begin
                                res_status_next = STATUS_ZERO;
                            end
                            else if (!add_ok)
                            begin
                                res_status_next = STATUS_REJECT;
                            end
                            else
                            begin
                                total_next = sum[DATA_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (total_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            total_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = STATUS_DONE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    rnd_next = mod_rem;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    res_type_next = rd_data.type_val;
                end
                else if (!scan_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_type_next   = res_type_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rnd_reg        <= rnd_next;
        res_type_reg   <= res_type_next;
        res_status_reg <= res_status_next;
        out_type_reg   <= out_type_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_type_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

@@ hdl/wrs_ram.sv @@
`timescale 1ns / 1ps

module wrs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/wrs_mod.sv @@
`timescale 1ns / 1ps

module wrs_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wrs_pkg::DATA_W-1:0] dividend,
    input  logic [wrs_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [wrs_pkg::DATA_W-1:0] remainder
);

    import wrs_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] num_reg, num_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, num_reg[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DATA_W-2:0], 1'b0};
            if (!rem_sub[DATA_W])
            begin
                rem_next = rem_sub[DATA_W-1:0];
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
